// ===== sv/radio_frame_auto_ack_responder_assert.svh =====
// Assertion macros shared by the responder RTL.
// No dependencies; included by modules that carry checks.
`ifndef RADIO_FRAME_AUTO_ACK_RESPONDER_ASSERT_SVH
`define RADIO_FRAME_AUTO_ACK_RESPONDER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RFAR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rfar assertion failed");

// Next-cycle implication, checked outside reset.
`define RFAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rfar assertion failed");

`endif

// ===== sv/rfar_pkg.sv =====
// Types and constants of the radio frame auto-ack responder.
// No dependencies; imported by every responder module.
`default_nettype none
package rfar_pkg;

    // configuration register indexes
    localparam logic [1:0] CfgRxEnable   = 2'd0;
    localparam logic [1:0] CfgAutoAddr   = 2'd1;
    localparam logic [1:0] CfgThermAddr  = 2'd2;

    // message types that trigger acks
    localparam logic [7:0] TypeA         = 8'h30;
    localparam logic [7:0] TypeB         = 8'h40;
    localparam logic [7:0] TypeC         = 8'h50;

    localparam logic [6:0] ThermLen      = 7'd11;
    localparam logic [6:0] HeaderLen     = 7'd9;

    // ack frame contents
    localparam logic [7:0] AckLenByte    = 8'd11;
    localparam logic [7:0] AckTypeByte   = 8'd2;
    localparam logic [3:0] AckLastIdx    = 4'd11;

    // job queue between parser and ack generator
    localparam int QDepth = 2;
    localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef struct packed {
        logic        do_auto;
        logic        do_therm;
        logic [7:0]  counter;
        logic [23:0] dst;
        logic [23:0] src;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage
`default_nettype wire

// ===== sv/rfar_front.sv =====
// Frame parser and rule check: holds the config registers and header fields.
// Depends on rfar_pkg.
`default_nettype none
module rfar_front
    import rfar_pkg::*;
#(
    parameter int MAX_FRAME = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_push,
    output t_job             o_job
);

    logic        r_rx_en;
    logic [23:0] r_auto_addr, r_therm_addr;
    logic [6:0]  r_pos, n_pos;
    logic [6:0]  r_len, n_len;
    logic [7:0]  r_cnt, n_cnt;
    logic [7:0]  r_type, n_type;
    logic [23:0] r_src, n_src;
    logic [23:0] r_dst, n_dst;
    logic [6:0]  len_clamped;
    logic        hit_auto, hit_therm, frame_end;

    always_comb begin
        len_clamped = i_rx_byte[6:0];
        if (32'(len_clamped) >= MAX_FRAME) begin
            len_clamped = 7'(MAX_FRAME - 1);
        end
    end

    always_comb begin
        n_pos     = r_pos;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_type    = r_type;
        n_src     = r_src;
        n_dst     = r_dst;
        frame_end = 1'b0;
        if (i_accept && r_rx_en) begin
            if (r_pos == 7'd0) begin
                // length byte opens a frame; zero length ends it with no header
                n_len  = len_clamped;
                n_cnt  = 8'd0;
                n_type = 8'd0;
                n_src  = 24'd0;
                n_dst  = 24'd0;
                n_pos  = (len_clamped != 7'd0) ? 7'd1 : 7'd0;
            end else begin
                if (r_pos == 7'd1) begin
                    n_cnt = i_rx_byte;
                end else if (r_pos == 7'd3) begin
                    n_type = i_rx_byte;
                end else if (r_pos inside {[7'd4:7'd6]}) begin
                    n_src = {r_src[15:0], i_rx_byte};
                end else if (r_pos inside {[7'd7:7'd9]}) begin
                    n_dst = {r_dst[15:0], i_rx_byte};
                end
                if (r_pos >= r_len) begin
                    frame_end = 1'b1;
                    n_pos     = 7'd0;
                end else begin
                    n_pos = r_pos + 7'd1;
                end
            end
        end
    end

    // rules see the header including the byte taken this cycle
    always_comb begin
        hit_auto  = (r_len >= HeaderLen) && (r_auto_addr != 24'd0)
                    && (n_type inside {TypeA, TypeB, TypeC})
                    && (n_dst == r_auto_addr);
        hit_therm = (r_len >= HeaderLen) && (r_therm_addr != 24'd0)
                    && (r_len == ThermLen) && (n_type == TypeB)
                    && (n_dst == r_therm_addr);
    end

    assign o_push         = frame_end && (hit_auto || hit_therm);
    assign o_job.do_auto  = hit_auto;
    assign o_job.do_therm = hit_therm;
    assign o_job.counter  = n_cnt;
    assign o_job.dst      = n_dst;
    assign o_job.src      = n_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_en      <= 1'b0;
            r_auto_addr  <= 24'd0;
            r_therm_addr <= 24'd0;
            r_pos        <= 7'd0;
            r_len        <= 7'd0;
            r_cnt        <= 8'd0;
            r_type       <= 8'd0;
            r_src        <= 24'd0;
            r_dst        <= 24'd0;
        end else begin
            r_pos  <= n_pos;
            r_len  <= n_len;
            r_cnt  <= n_cnt;
            r_type <= n_type;
            r_src  <= n_src;
            r_dst  <= n_dst;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgRxEnable:  r_rx_en      <= i_cfg_data[0];
                    CfgAutoAddr:  r_auto_addr  <= i_cfg_data;
                    CfgThermAddr: r_therm_addr <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/rfar_fifo.sv =====
// Short job queue between the parser and the ack generator.
// Depends on rfar_pkg and the assertion macro header.
`default_nettype none
`include "radio_frame_auto_ack_responder_assert.svh"
module rfar_fifo
    import rfar_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output t_qstat    o_stat
);

    t_job             r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCntW-1:0] r_count;

    assign o_job        = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == QCntW'(0));
    assign o_stat.full  = (r_count == QCntW'(QDepth));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == QDepth - 1) ? '0 : r_wr_ptr + QPtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == QDepth - 1) ? '0 : r_rd_ptr + QPtrW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCntW'(1);
                2'b01:   r_count <= r_count - QCntW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `RFAR_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push, !o_stat.full || i_pop)
    `RFAR_ASSERT_IMPLY(a_no_underflow, i_clk, i_rst_n, i_pop, !o_stat.empty)
    `RFAR_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + QCntW'(1))
    `RFAR_ASSERT_IMPLY(a_count_range, i_clk, i_rst_n, 1'b1, 32'(r_count) <= QDepth)

endmodule
`default_nettype wire

// ===== sv/rfar_back.sv =====
// Ack generator: plays out one or two 12-byte ack frames per queued job.
// Depends on rfar_pkg and the assertion macro header.
`default_nettype none
`include "radio_frame_auto_ack_responder_assert.svh"
module rfar_back
    import rfar_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_job        i_job,
    input  wire t_qstat      i_qstat,
    output logic             o_pop,
    output logic             o_ack_valid,
    input  wire logic        i_ack_stall,
    output logic [7:0]       o_ack_byte,
    output logic             o_ack_last,
    output logic             o_ack_kind,
    output logic             o_run_last
);

    logic        r_busy;
    logic [3:0]  r_idx;
    logic        r_phase;       // 0 auto-ack frame, 1 thermostat frame
    logic        r_therm;       // thermostat frame still owed for this job
    logic [7:0]  r_cnt;
    logic [23:0] r_src, r_dst;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last, r_out_kind, r_out_run;

    logic        load_out, frame_done, job_done;
    logic [7:0]  cur_byte;

    assign load_out   = !r_out_valid || !i_ack_stall;
    assign frame_done = r_busy && load_out && (r_idx == AckLastIdx);
    assign job_done   = frame_done && (r_phase || !r_therm);
    assign o_pop      = !i_qstat.empty && (!r_busy || job_done);

    always_comb begin
        case (r_idx)
            4'd0:    cur_byte = AckLenByte;
            4'd1:    cur_byte = r_cnt;
            4'd3:    cur_byte = AckTypeByte;
            4'd4:    cur_byte = r_dst[23:16];
            4'd5:    cur_byte = r_dst[15:8];
            4'd6:    cur_byte = r_dst[7:0];
            4'd7:    cur_byte = r_src[23:16];
            4'd8:    cur_byte = r_src[15:8];
            4'd9:    cur_byte = r_src[7:0];
            default: cur_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cnt <= i_job.counter;
            r_src <= i_job.src;
            r_dst <= i_job.dst;
        end
        if (load_out) begin
            r_out_byte <= cur_byte;
            r_out_last <= (r_idx == AckLastIdx);
            r_out_kind <= r_phase;
            r_out_run  <= (r_idx == AckLastIdx) && (r_phase || !r_therm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 4'd0;
            r_phase     <= 1'b0;
            r_therm     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= r_busy;
            end
            if (o_pop) begin
                r_busy  <= 1'b1;
                r_idx   <= 4'd0;
                r_phase <= !i_job.do_auto;
                r_therm <= i_job.do_therm;
            end else if (job_done) begin
                r_busy <= 1'b0;
                r_idx  <= 4'd0;
            end else if (frame_done) begin
                r_idx   <= 4'd0;
                r_phase <= 1'b1;
            end else if (r_busy && load_out) begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    assign o_ack_valid = r_out_valid;
    assign o_ack_byte  = r_out_byte;
    assign o_ack_last  = r_out_last;
    assign o_ack_kind  = r_out_kind;
    assign o_run_last  = r_out_run;

    `RFAR_ASSERT_IMPLY(a_idx_range, i_clk, i_rst_n, r_busy, r_idx <= AckLastIdx)
    `RFAR_ASSERT_IMPLY(a_run_ends_frame, i_clk, i_rst_n, r_out_valid && r_out_run, r_out_last)
    `RFAR_ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, r_out_valid && i_ack_stall, r_out_valid && $stable(r_out_byte))

endmodule
`default_nettype wire

// ===== sv/radio_frame_auto_ack_responder.sv =====
// Top level of the radio frame auto-ack responder: parser, job queue, ack generator.
// Depends on rfar_pkg, rfar_front, rfar_fifo and rfar_back.
`default_nettype none
// Receives frame bytes one transfer at a time; the first byte of each frame is its
// length (low 7 bits, clamped to MAX_FRAME-1), and the parser keeps message counter,
// type, source and destination. On the last byte the auto-ack and fake thermostat
// rules are evaluated against the programmed addresses; each rule that passes yields
// a 12-byte ack frame (auto-ack first), so one frame produces 0, 12 or 24 output
// transfers, and o_run_last marks the final one. Rate: the parser takes one byte
// every cycle while the queue is not full; a matching frame hands a job to a
// two-entry queue, and the ack generator emits one ack byte per cycle unless the
// output stalls; a queued job follows the previous one with no gap. From an idle
// generator, once the frame's last byte is taken, the job passes through the queue
// and the busy state, and the first ack byte through the output register. Input
// stalls only when both queue entries hold jobs that the generator has not started.
// Configuration writes via i_cfg_we/i_cfg_idx/i_cfg_data (0 rx enable, 1 auto-ack
// address, 2 thermostat address) are to be issued while no frame is in flight;
// with rx disabled, bytes are still taken but ignored.
module radio_frame_auto_ack_responder
    import rfar_pkg::*;
#(
    parameter int MAX_FRAME = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic        i_rx_valid,
    output logic             o_rx_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_ack_valid,
    input  wire logic        i_ack_stall,
    output logic [7:0]       o_ack_byte,
    output logic             o_ack_last,
    output logic             o_ack_kind,
    output logic             o_run_last
);

    t_job   push_job, pop_job;
    t_qstat qstat;
    logic   push, pop, rx_accept;

    // stall is taken straight from queue fullness, never from valid
    assign o_rx_stall = qstat.full;
    assign rx_accept  = i_rx_valid && !o_rx_stall;

    rfar_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (rx_accept),
        .i_rx_byte  (i_rx_byte),
        .o_push     (push),
        .o_job      (push_job)
    );

    rfar_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_stat  (qstat)
    );

    rfar_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (pop_job),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_ack_valid (o_ack_valid),
        .i_ack_stall (i_ack_stall),
        .o_ack_byte  (o_ack_byte),
        .o_ack_last  (o_ack_last),
        .o_ack_kind  (o_ack_kind),
        .o_run_last  (o_run_last)
    );

endmodule
`default_nettype wire

// ===== bench/ack_frame_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the radio frame auto-ack responder: mirrors register writes,
// predicts the ack transfers caused by each rx byte and checks the ack channel.
// Depends on rfar_pkg.
module ack_frame_checker
    import rfar_pkg::*;
#(
    parameter int MAX_FRAME = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_rx_valid,
    input  logic        i_rx_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_ack_valid,
    input  logic        i_ack_stall,
    input  logic [7:0]  i_ack_byte,
    input  logic        i_ack_last,
    input  logic        i_ack_kind,
    input  logic        i_run_last,
    output int          o_mismatches,
    output int          o_acks_pending
);

    localparam logic KindAuto  = 1'b0;
    localparam logic KindTherm = 1'b1;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       kind;
        logic       run_last;
    } t_ack_beat;

    t_ack_beat   expected_acks[$];

    // register mirror
    logic        rx_on;
    logic [23:0] auto_addr;
    logic [23:0] therm_addr;

    // frame parser mirror
    logic [6:0]  rx_pos;
    logic [6:0]  frame_len;
    logic [7:0]  msg_counter;
    logic [7:0]  msg_type;
    logic [23:0] src_addr;
    logic [23:0] dst_addr;

    // ack layout: length, counter, flags, type, then dst and src swapped in
    function automatic logic [7:0] ack_frame_byte(input int idx);
        case (idx)
            0:       ack_frame_byte = AckLenByte;
            1:       ack_frame_byte = msg_counter;
            3:       ack_frame_byte = AckTypeByte;
            4:       ack_frame_byte = dst_addr[23:16];
            5:       ack_frame_byte = dst_addr[15:8];
            6:       ack_frame_byte = dst_addr[7:0];
            7:       ack_frame_byte = src_addr[23:16];
            8:       ack_frame_byte = src_addr[15:8];
            9:       ack_frame_byte = src_addr[7:0];
            default: ack_frame_byte = 8'h00;
        endcase
    endfunction

    task automatic queue_ack_frame(input logic kind);
        t_ack_beat beat;
        int        i;
        for (i = 0; i <= AckLastIdx; i++) begin
            beat.value    = ack_frame_byte(i);
            beat.last     = (i == AckLastIdx);
            beat.kind     = kind;
            beat.run_last = 1'b0;
            expected_acks.push_back(beat);
        end
    endtask

    task automatic close_frame();
        logic      has_header;
        logic      auto_hit;
        logic      therm_hit;
        t_ack_beat tail;
        has_header = (frame_len >= HeaderLen);
        auto_hit   = has_header && (auto_addr != 24'd0) &&
                     (msg_type == TypeA || msg_type == TypeB || msg_type == TypeC) &&
                     (dst_addr == auto_addr);
        therm_hit  = has_header && (therm_addr != 24'd0) && (frame_len == ThermLen) &&
                     (msg_type == TypeB) && (dst_addr == therm_addr);
        if (auto_hit)
            queue_ack_frame(KindAuto);
        if (therm_hit)
            queue_ack_frame(KindTherm);
        if (auto_hit || therm_hit) begin
            tail          = expected_acks.pop_back();
            tail.run_last = 1'b1;
            expected_acks.push_back(tail);
        end
    endtask

    task automatic take_rx_byte(input logic [7:0] b);
        logic [6:0] len;
        if (rx_on) begin
            if (rx_pos == 7'd0) begin
                // length byte opens a frame and wipes the header fields
                len = b[6:0];
                if (len >= MAX_FRAME)
                    len = 7'(MAX_FRAME - 1);
                frame_len   = len;
                msg_counter = 8'd0;
                msg_type    = 8'd0;
                src_addr    = 24'd0;
                dst_addr    = 24'd0;
                if (frame_len == 7'd0)
                    close_frame();
                else
                    rx_pos = 7'd1;
            end else begin
                case (rx_pos)
                    7'd1:             msg_counter = b;
                    7'd3:             msg_type    = b;
                    7'd4, 7'd5, 7'd6: src_addr    = {src_addr[15:0], b};
                    7'd7, 7'd8, 7'd9: dst_addr    = {dst_addr[15:0], b};
                    default: ;
                endcase
                if (rx_pos >= frame_len) begin
                    rx_pos = 7'd0;
                    close_frame();
                end else begin
                    rx_pos = rx_pos + 7'd1;
                end
            end
        end
    endtask

    task automatic check_ack_beat();
        t_ack_beat want;
        if (expected_acks.size() == 0) begin
            $error("ack transfer with nothing expected: ack_byte %02h", i_ack_byte);
            o_mismatches++;
        end else begin
            want = expected_acks.pop_front();
            if (i_ack_byte !== want.value) begin
                $error("ack_byte: expected %02h, got %02h", want.value, i_ack_byte);
                o_mismatches++;
            end
            if (i_ack_last !== want.last) begin
                $error("ack_last: expected %0b, got %0b", want.last, i_ack_last);
                o_mismatches++;
            end
            if (i_ack_kind !== want.kind) begin
                $error("ack_kind: expected %0b, got %0b", want.kind, i_ack_kind);
                o_mismatches++;
            end
            if (i_run_last !== want.run_last) begin
                $error("run_last: expected %0b, got %0b", want.run_last, i_run_last);
                o_mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_on       = 1'b0;
            auto_addr   = 24'd0;
            therm_addr  = 24'd0;
            rx_pos      = 7'd0;
            frame_len   = 7'd0;
            msg_counter = 8'd0;
            msg_type    = 8'd0;
            src_addr    = 24'd0;
            dst_addr    = 24'd0;
            expected_acks.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgRxEnable:  rx_on      = i_cfg_data[0];
                    CfgAutoAddr:  auto_addr  = i_cfg_data;
                    CfgThermAddr: therm_addr = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_rx_valid && !i_rx_stall)
                take_rx_byte(i_rx_byte);
            if (i_ack_valid && !i_ack_stall)
                check_ack_beat();
        end
        o_acks_pending = expected_acks.size();
    end

endmodule

// ===== bench/tb_radio_frame_auto_ack_responder.sv =====
`timescale 1ns / 100ps
// Testbench top for the radio frame auto-ack responder: drives frames, register
// writes and ack back-pressure; ack_frame_checker does the prediction and checks.
// Depends on rfar_pkg, ack_frame_checker and the responder RTL.
module tb_radio_frame_auto_ack_responder;
    import rfar_pkg::*;

    localparam int MAX_FRAME     = 32;
    localparam int CLK_PERIOD    = 4;
    // receiver hold-off long enough to fill the job queue and stall rx
    localparam int HOLD_CYCLES   = 300;
    // cycles allowed after the last expected ack for frames that end silently
    localparam int SETTLE_CYCLES = 8;
    // cycles without any transfer before the run is declared hung
    localparam int IDLE_LIMIT    = 2000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_idx   = CfgRxEnable;
    logic [23:0] cfg_data  = 24'd0;
    logic        rx_valid  = 1'b0;
    logic        rx_stall;
    logic [7:0]  rx_byte   = 8'd0;
    logic        ack_valid;
    logic        ack_stall = 1'b1;
    logic [7:0]  ack_byte;
    logic        ack_last;
    logic        ack_kind;
    logic        run_last;

    int          mismatches;
    int          acks_pending;

    // stimulus-side copies of the programmed addresses, used to aim frames
    logic [23:0] auto_addr_set  = 24'd0;
    logic [23:0] therm_addr_set = 24'd0;
    int          rx_bytes_sent  = 0;

    // pacing knobs: steady = no idling on that side
    bit          rx_steady      = 1'b0;
    bit          ack_steady     = 1'b0;
    bit          hold_off_req   = 1'b0;
    int          ack_hold_left  = 0;
    int          ack_burst_left = 0;
    int          ack_roll;
    int          idle_cycles    = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    radio_frame_auto_ack_responder #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_rx_valid  (rx_valid),
        .o_rx_stall  (rx_stall),
        .i_rx_byte   (rx_byte),
        .o_ack_valid (ack_valid),
        .i_ack_stall (ack_stall),
        .o_ack_byte  (ack_byte),
        .o_ack_last  (ack_last),
        .o_ack_kind  (ack_kind),
        .o_run_last  (run_last)
    );

    ack_frame_checker #(
        .MAX_FRAME (MAX_FRAME)
    ) u_ack_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_rx_valid     (rx_valid),
        .i_rx_stall     (rx_stall),
        .i_rx_byte      (rx_byte),
        .i_ack_valid    (ack_valid),
        .i_ack_stall    (ack_stall),
        .i_ack_byte     (ack_byte),
        .i_ack_last     (ack_last),
        .i_ack_kind     (ack_kind),
        .i_run_last     (run_last),
        .o_mismatches   (mismatches),
        .o_acks_pending (acks_pending)
    );

    // Ack side back-pressure, decided at every falling edge. A hold-off
    // request from the stimulus is counted down here, in cycles.
    always @(negedge clk) begin
        if (hold_off_req) begin
            hold_off_req  = 1'b0;
            ack_hold_left = HOLD_CYCLES;
        end
        if (ack_hold_left > 0) begin
            ack_hold_left--;
            ack_stall <= 1'b1;
        end else if (ack_burst_left > 0) begin
            ack_burst_left--;
            ack_stall <= 1'b1;
        end else if (ack_steady) begin
            ack_stall <= 1'b0;
        end else begin
            ack_roll = $urandom_range(0, 99);
            if (ack_roll < 70) begin
                ack_stall <= 1'b0;
            end else begin
                // mostly short stalls, now and then a long one
                ack_burst_left = (ack_roll < 95) ? $urandom_range(0, 2)
                                                 : $urandom_range(10, 40);
                ack_stall <= 1'b1;
            end
        end
    end

    // Watchdog: any transfer or register write restarts the count.
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (rx_valid && !rx_stall) || (ack_valid && !ack_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Gap before the next rx byte: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        if (rx_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Called and returns at a falling edge; valid stays high after the
    // transfer so back-to-back bytes need no extra assignment.
    task automatic send_rx_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (rx_stall);
        @(negedge clk);
        rx_bytes_sent++;
    endtask

    // One complete frame: length byte, then header fields at their positions
    // and random filler everywhere else.
    task automatic send_frame(input logic [7:0]  len_byte, input logic [7:0] counter,
                              input logic [7:0]  mtype, input logic [23:0] src,
                              input logic [23:0] dst);
        int         n;
        int         p;
        logic [7:0] b;
        n = int'(len_byte[6:0]);
        if (n >= MAX_FRAME)
            n = MAX_FRAME - 1;
        send_rx_byte(len_byte);
        for (p = 1; p <= n; p++) begin
            case (p)
                1:       b = counter;
                3:       b = mtype;
                4:       b = src[23:16];
                5:       b = src[15:8];
                6:       b = src[7:0];
                7:       b = dst[23:16];
                8:       b = dst[15:8];
                9:       b = dst[7:0];
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_rx_byte(b);
        end
    endtask

    // Mostly frames that can hit a rule, the rest short, long or off-target.
    task automatic send_random_frame();
        int          r;
        logic [6:0]  len;
        logic [7:0]  len_byte;
        logic [7:0]  mtype;
        logic [7:0]  counter;
        logic [23:0] src;
        logic [23:0] dst;
        r = $urandom_range(0, 99);
        if (r < 55)
            len = 7'($urandom_range(9, 11));
        else if (r < 70)
            len = 7'($urandom_range(0, 8));
        else if (r < 88)
            len = 7'($urandom_range(12, MAX_FRAME - 1));
        else
            len = 7'($urandom_range(MAX_FRAME, 127));    // clamped by the block
        len_byte    = {1'b0, len};
        len_byte[7] = 1'($urandom_range(0, 1));          // ignored bit
        r = $urandom_range(0, 99);
        if (r < 20)
            mtype = TypeA;
        else if (r < 55)
            mtype = TypeB;
        else if (r < 75)
            mtype = TypeC;
        else
            mtype = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 40)
            dst = auto_addr_set;
        else if (r < 75)
            dst = therm_addr_set;
        else
            dst = 24'($urandom);
        counter = 8'($urandom_range(0, 255));
        src     = 24'($urandom);
        send_frame(len_byte, counter, mtype, src, dst);
    endtask

    task automatic run_random_frames(input int n_bytes);
        int target;
        target = rx_bytes_sent + n_bytes;
        while (rx_bytes_sent < target)
            send_random_frame();
    endtask

    // Drop rx valid and wait until every predicted ack has come out, plus a
    // settling wait for a frame that ended without acks.
    task automatic settle();
        rx_valid <= 1'b0;
        while (acks_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes all three registers on consecutive cycles; block must be idle.
    task automatic program_responder(input logic rx_en, input logic [23:0] auto_a,
                                     input logic [23:0] therm_a);
        auto_addr_set  = auto_a;
        therm_addr_set = therm_a;
        cfg_we   <= 1'b1;
        cfg_idx  <= CfgRxEnable;
        cfg_data <= {23'd0, rx_en};
        @(negedge clk);
        cfg_idx  <= CfgAutoAddr;
        cfg_data <= auto_a;
        @(negedge clk);
        cfg_idx  <= CfgThermAddr;
        cfg_data <= therm_a;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [23:0] shared_addr;
        int          i;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: both rules aimed at one address.
        program_responder(1'b1, 24'hC3A55A, 24'hC3A55A);
        send_frame(8'h80, 8'h00, 8'h00, 24'h000000, 24'h000000);  // zero length, bit 7 set
        send_frame(8'd11, 8'hFF, TypeB, 24'hFFFFFF, 24'hC3A55A);  // both rules fire
        send_frame(8'd9, 8'h00, TypeA, 24'h000000, 24'hC3A55A);   // auto-ack only
        send_frame(8'd3, 8'h12, TypeB, 24'h000000, 24'h000000);   // header cut short
        settle();

        // Address extremes.
        program_responder(1'b1, 24'hFFFFFF, 24'h000001);
        run_random_frames(6);
        settle();

        // Auto-ack disabled, ack side never stalls.
        ack_steady = 1'b1;
        program_responder(1'b1, 24'h000000, 24'($urandom_range(1, 24'hFFFFFF)));
        run_random_frames(4);
        settle();
        ack_steady = 1'b0;

        // Thermostat disabled, rx side never idles.
        rx_steady = 1'b1;
        program_responder(1'b1, 24'($urandom_range(1, 24'hFFFFFF)), 24'h000000);
        run_random_frames(4);
        settle();
        rx_steady = 1'b0;

        // Receiver off: bytes are taken and dropped, nothing comes out.
        program_responder(1'b0, 24'($urandom), 24'($urandom));
        for (i = 0; i < 12; i++)
            send_rx_byte(8'($urandom_range(0, 255)));
        settle();

        // Both rules on one address; hold the ack side off while thermostat
        // frames pile up, so the job queue fills and rx stalls.
        shared_addr = 24'($urandom_range(1, 24'hFFFFFF));
        program_responder(1'b1, shared_addr, shared_addr);
        hold_off_req = 1'b1;
        for (i = 0; i < 4; i++)
            send_frame(8'd11, 8'($urandom_range(0, 255)), TypeB, 24'($urandom),
                       shared_addr);
        run_random_frames(6);
        settle();

        if (mismatches == 0 && acks_pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
